FILE: rtl/vvo_pkg.sv
package vvo_pkg;

   localparam int WORD_BITS      = 32;
   localparam int FRAC_BITS      = 16;
   localparam int STEP_BITS      = 16;
   localparam int CSR_INDEX_BITS = 2;
   // wide enough for d^3 and for m*|r| scaled by 2^(2F)
   localparam int WIDE_BITS      = 4 * WORD_BITS;
   // root of |r|^2, where |r| has WORD_BITS+1 bits on each axis
   localparam int ROOT_BITS      = WORD_BITS + 2;
   localparam int COUNT_BITS     = $clog2(WIDE_BITS + 1);

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [WIDE_BITS-1:0] wide_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TIME_STEP = 2'd0,
      CSR_GRAV      = 2'd1,
      CSR_ATTR_X    = 2'd2,
      CSR_ATTR_Y    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      PH_VDT,
      PH_ADT,
      PH_SDT,
      PH_SQ,
      PH_SQRT,
      PH_DD,
      PH_DDD,
      PH_MR,
      PH_DIV,
      PH_VEL
   } phase_type;

   typedef struct packed {
      logic     ovf;
      word_type value;
   } sat_type;

   function automatic sat_type sat_word(input wide_type v);
      wide_type hi_lim;
      wide_type lo_lim;
      sat_type  r;
      hi_lim = wide_type'({1'b0, {(WORD_BITS-1){1'b1}}});
      lo_lim = -hi_lim - wide_type'(1);
      r.ovf   = 1'b0;
      r.value = v[WORD_BITS-1:0];
      if (v > hi_lim) begin
         r.ovf   = 1'b1;
         r.value = hi_lim[WORD_BITS-1:0];
      end else if (v < lo_lim) begin
         r.ovf   = 1'b1;
         r.value = lo_lim[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/vvo_alu.sv
module vvo_alu (
   input  logic                clock,
   input  logic                reset,
   input  vvo_pkg::alu_cmd_type cmd,
   input  vvo_pkg::wide_type   opnd_a,
   input  vvo_pkg::wide_type   opnd_b,
   output logic                done,
   output vvo_pkg::wide_type   result
);
   import vvo_pkg::*;

   localparam logic [WIDE_BITS-1:0] ROOT_ONE = WIDE_BITS'(1) << (2 * ROOT_BITS - 2);

   logic                  busy_ff, busy_in;
   alu_op_type            op_ff, op_in;
   logic [WIDE_BITS-1:0]  x_ff, x_in;
   logic [WIDE_BITS-1:0]  y_ff, y_in;
   logic [WIDE_BITS-1:0]  z_ff, z_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [WIDE_BITS-1:0]  rem_shift;
   logic [WIDE_BITS:0]    rem_diff;
   logic [WIDE_BITS-1:0]  root_trial;

   assign rem_shift  = {z_ff[WIDE_BITS-2:0], x_ff[WIDE_BITS-1]};
   assign rem_diff   = {1'b0, rem_shift} - {1'b0, y_ff};
   assign root_trial = y_ff + z_ff;

   // mul: x multiplicand, y multiplier, z product
   // div: x numerator shifting into quotient, y divisor, z remainder
   // sqrt: x remainder, y root, z trial bit
   always_comb begin
      busy_in  = busy_ff;
      op_in    = op_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      count_in = count_ff;
      done     = 1'b0;
      if (busy_ff) begin
         case (op_ff)
            ALU_MUL: begin
               if (y_ff == '0) begin
                  done    = 1'b1;
                  busy_in = 1'b0;
               end else begin
                  if (y_ff[0]) begin
                     z_in = z_ff + x_ff;
                  end
                  x_in = x_ff << 1;
                  y_in = y_ff >> 1;
               end
            end
            ALU_DIV: begin
               if (count_ff == '0) begin
                  done    = 1'b1;
                  busy_in = 1'b0;
               end else begin
                  count_in = count_ff - 1'b1;
                  if (!rem_diff[WIDE_BITS]) begin
                     z_in = rem_diff[WIDE_BITS-1:0];
                     x_in = {x_ff[WIDE_BITS-2:0], 1'b1};
                  end else begin
                     z_in = rem_shift;
                     x_in = {x_ff[WIDE_BITS-2:0], 1'b0};
                  end
               end
            end
            ALU_SQRT: begin
               if (z_ff == '0) begin
                  done    = 1'b1;
                  busy_in = 1'b0;
               end else begin
                  if (x_ff >= root_trial) begin
                     x_in = x_ff - root_trial;
                     y_in = (y_ff >> 1) + z_ff;
                  end else begin
                     y_in = y_ff >> 1;
                  end
                  z_in = z_ff >> 2;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         x_in    = opnd_a;
         y_in    = opnd_b;
         z_in    = '0;
         case (cmd.op)
            ALU_DIV: begin
               count_in = COUNT_BITS'(WIDE_BITS);
            end
            ALU_SQRT: begin
               y_in = '0;
               z_in = ROOT_ONE;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (op_ff)
         ALU_MUL:  result = z_ff;
         ALU_DIV:  result = x_ff;
         ALU_SQRT: result = y_ff;
         default:  result = z_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         op_ff   <= ALU_MUL;
      end else begin
         busy_ff <= busy_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      count_ff <= count_in;
   end

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("unit done held longer than one cycle");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("unit started while busy");

endmodule

FILE: rtl/velocity_verlet_orbit_step.sv
// All arithmetic runs on one shared shift-add unit, which multiplies bit by bit
// over the multiplier, divides by restoring division once per axis and takes the
// root bit by bit; every operation is first issued from the issue state.
// Throughput: one item at a time; the next item is taken once the result sits in
// the output register. Synchronous reset clears state, counter, config registers
// and the output valid.
module velocity_verlet_orbit_step (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic signed [vvo_pkg::WORD_BITS-1:0] req_pos_x_in,
   input  logic signed [vvo_pkg::WORD_BITS-1:0] req_pos_y_in,
   input  logic signed [vvo_pkg::WORD_BITS-1:0] req_vel_x_in,
   input  logic signed [vvo_pkg::WORD_BITS-1:0] req_vel_y_in,
   input  logic signed [vvo_pkg::WORD_BITS-1:0] req_acc_x_in,
   input  logic signed [vvo_pkg::WORD_BITS-1:0] req_acc_y_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [vvo_pkg::STEP_BITS-1:0]      rsp_step_index,
   output logic signed [vvo_pkg::WORD_BITS-1:0] rsp_pos_x_out,
   output logic signed [vvo_pkg::WORD_BITS-1:0] rsp_pos_y_out,
   output logic signed [vvo_pkg::WORD_BITS-1:0] rsp_vel_x_out,
   output logic signed [vvo_pkg::WORD_BITS-1:0] rsp_vel_y_out,
   output logic signed [vvo_pkg::WORD_BITS-1:0] rsp_acc_x_out,
   output logic signed [vvo_pkg::WORD_BITS-1:0] rsp_acc_y_out,
   output logic                               rsp_overflow_flag,
   output logic                               rsp_singular_flag,
   input  logic                               csr_wr_en,
   input  logic [vvo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [vvo_pkg::WORD_BITS-1:0]      csr_wdata
);
   import vvo_pkg::*;

   localparam logic [WIDE_BITS-1:0] MAG_MIN = WIDE_BITS'(1) << (WORD_BITS - 1);
   localparam logic [WIDE_BITS-1:0] MAG_MAX = MAG_MIN - WIDE_BITS'(1);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      ax_ff, ax_in;

   logic [WORD_BITS-1:0] dt_ff, dt_in;
   logic [WORD_BITS-1:0] m_ff, m_in;
   word_type             attr_ff [2];
   word_type             attr_in [2];

   word_type p_ff [2];
   word_type p_in [2];
   word_type v_ff [2];
   word_type v_in [2];
   word_type a_ff [2];
   word_type a_in [2];
   logic [STEP_BITS-1:0] step_count_ff, step_count_in;

   word_type np_ff [2];
   word_type np_in [2];
   word_type nv_ff [2];
   word_type nv_in [2];
   word_type na_ff [2];
   word_type na_in [2];
   logic signed [WORD_BITS:0] r_ff [2];
   logic signed [WORD_BITS:0] r_in [2];
   wide_type                  acc_ff, acc_in;
   wide_type                  tmp_ff, tmp_in;
   logic [ROOT_BITS-1:0]      d_ff, d_in;
   logic                      ovf_ff, ovf_in;
   logic                      sing_ff, sing_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STEP_BITS-1:0] out_index_ff, out_index_in;
   word_type             out_pos_ff [2];
   word_type             out_pos_in [2];
   word_type             out_vel_ff [2];
   word_type             out_vel_in [2];
   word_type             out_acc_ff [2];
   word_type             out_acc_in [2];
   logic                 out_ovf_ff, out_ovf_in;
   logic                 out_sing_ff, out_sing_in;

   alu_cmd_type alu_cmd;
   wide_type    alu_a;
   wide_type    alu_b;
   logic        alu_done;
   wide_type    alu_res;

   logic                      out_load;
   logic signed [WORD_BITS:0] r_now;
   logic [WORD_BITS:0]        r_now_mag;
   logic signed [WORD_BITS:0] r_cur;
   logic [WORD_BITS:0]        r_cur_mag;
   logic signed [WORD_BITS:0] a_sum;
   sat_type                   pos_sat;
   sat_type                   vel_sat;
   logic [WIDE_BITS-1:0]      quot;
   logic                      r_pos;
   logic [WIDE_BITS-1:0]      quot_lim;
   logic                      quot_over;
   logic [WIDE_BITS-1:0]      quot_sat;
   word_type                  acc_val;

   vvo_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opnd_a (alu_a),
      .opnd_b (alu_b),
      .done   (alu_done),
      .result (alu_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // offset from the attractor, kept exact in one extra bit
   assign r_now     = (WORD_BITS+1)'(np_ff[ax_ff]) - (WORD_BITS+1)'(attr_ff[ax_ff]);
   assign r_now_mag = r_now[WORD_BITS] ? (~r_now + 1'b1) : r_now;
   assign r_cur     = r_ff[ax_ff];
   assign r_cur_mag = r_cur[WORD_BITS] ? (~r_cur + 1'b1) : r_cur;
   assign a_sum     = (WORD_BITS+1)'(a_ff[ax_ff]) + (WORD_BITS+1)'(na_ff[ax_ff]);

   assign pos_sat = sat_word(acc_ff + (alu_res >>> (FRAC_BITS + 1)));
   assign vel_sat = sat_word(wide_type'(v_ff[ax_ff]) + (alu_res >>> (FRAC_BITS + 1)));

   // acceleration points toward the attractor; magnitude limit depends on sign
   assign quot      = alu_res;
   assign r_pos     = !r_cur[WORD_BITS] && (r_cur != '0);
   assign quot_lim  = r_pos ? MAG_MIN : MAG_MAX;
   assign quot_over = quot > quot_lim;
   assign quot_sat  = quot_over ? quot_lim : quot;
   assign acc_val   = r_pos ? (~quot_sat[WORD_BITS-1:0]) + 1'b1 : quot_sat[WORD_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      ax_in         = ax_ff;
      dt_in         = dt_ff;
      m_in          = m_ff;
      attr_in       = attr_ff;
      p_in          = p_ff;
      v_in          = v_ff;
      a_in          = a_ff;
      step_count_in = step_count_ff;
      np_in         = np_ff;
      nv_in         = nv_ff;
      na_in         = na_ff;
      r_in          = r_ff;
      acc_in        = acc_ff;
      tmp_in        = tmp_ff;
      d_in          = d_ff;
      ovf_in        = ovf_ff;
      sing_in       = sing_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_index_in  = out_index_ff;
      out_pos_in    = out_pos_ff;
      out_vel_in    = out_vel_ff;
      out_acc_in    = out_acc_ff;
      out_ovf_in    = out_ovf_ff;
      out_sing_in   = out_sing_ff;
      alu_cmd.start = 1'b0;
      alu_cmd.op    = ALU_MUL;
      alu_a         = '0;
      alu_b         = wide_type'(dt_ff);

      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TIME_STEP: dt_in      = csr_wdata;
            CSR_GRAV:      m_in       = csr_wdata;
            CSR_ATTR_X:    attr_in[0] = csr_wdata;
            CSR_ATTR_Y:    attr_in[1] = csr_wdata;
            default:       dt_in      = dt_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_mode) begin
                  p_in[0]       = req_pos_x_in;
                  p_in[1]       = req_pos_y_in;
                  v_in[0]       = req_vel_x_in;
                  v_in[1]       = req_vel_y_in;
                  a_in[0]       = req_acc_x_in;
                  a_in[1]       = req_acc_y_in;
                  step_count_in = '0;
               end else begin
                  ovf_in   = 1'b0;
                  sing_in  = 1'b0;
                  ax_in    = 1'b0;
                  phase_in = PH_VDT;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            alu_cmd.start = 1'b1;
            state_in      = ST_WAIT;
            case (phase_ff)
               PH_VDT: alu_a = wide_type'(v_ff[ax_ff]);
               PH_ADT: alu_a = wide_type'(a_ff[ax_ff]);
               PH_SDT: alu_a = tmp_ff;
               PH_SQ: begin
                  r_in[ax_ff] = r_now;
                  alu_a       = wide_type'(r_now_mag);
                  alu_b       = wide_type'(r_now_mag);
               end
               PH_SQRT: begin
                  alu_cmd.op = ALU_SQRT;
                  alu_a      = acc_ff;
               end
               PH_DD: begin
                  alu_a = wide_type'(d_ff);
                  alu_b = wide_type'(d_ff);
               end
               PH_DDD: begin
                  alu_a = tmp_ff;
                  alu_b = wide_type'(d_ff);
               end
               PH_MR: begin
                  alu_a = wide_type'(r_cur_mag);
                  alu_b = wide_type'(m_ff);
               end
               PH_DIV: begin
                  alu_cmd.op = ALU_DIV;
                  alu_a      = tmp_ff;
                  alu_b      = acc_ff;
               end
               PH_VEL: alu_a = wide_type'(a_sum);
               default: state_in = ST_IDLE;
            endcase
         end
         ST_WAIT: begin
            if (alu_done) begin
               state_in = ST_ISSUE;
               case (phase_ff)
                  PH_VDT: begin
                     acc_in   = wide_type'(p_ff[ax_ff]) + (alu_res >>> FRAC_BITS);
                     phase_in = PH_ADT;
                  end
                  PH_ADT: begin
                     tmp_in   = alu_res >>> FRAC_BITS;
                     phase_in = PH_SDT;
                  end
                  PH_SDT: begin
                     np_in[ax_ff] = pos_sat.value;
                     ovf_in       = ovf_ff | pos_sat.ovf;
                     ax_in        = !ax_ff;
                     phase_in     = ax_ff ? PH_SQ : PH_VDT;
                  end
                  PH_SQ: begin
                     acc_in   = ax_ff ? (acc_ff + alu_res) : alu_res;
                     ax_in    = !ax_ff;
                     phase_in = ax_ff ? PH_SQRT : PH_SQ;
                  end
                  PH_SQRT: begin
                     d_in = alu_res[ROOT_BITS-1:0];
                     if (alu_res == '0) begin
                        // singular: no force, go straight to velocity
                        sing_in  = 1'b1;
                        na_in[0] = '0;
                        na_in[1] = '0;
                        ax_in    = 1'b0;
                        phase_in = PH_VEL;
                     end else begin
                        phase_in = PH_DD;
                     end
                  end
                  PH_DD: begin
                     tmp_in   = alu_res;
                     phase_in = PH_DDD;
                  end
                  PH_DDD: begin
                     acc_in   = alu_res;
                     ax_in    = 1'b0;
                     phase_in = PH_MR;
                  end
                  PH_MR: begin
                     tmp_in   = alu_res <<< (2 * FRAC_BITS);
                     phase_in = PH_DIV;
                  end
                  PH_DIV: begin
                     na_in[ax_ff] = acc_val;
                     ovf_in       = ovf_ff | quot_over;
                     ax_in        = !ax_ff;
                     phase_in     = ax_ff ? PH_VEL : PH_MR;
                  end
                  PH_VEL: begin
                     nv_in[ax_ff] = vel_sat.value;
                     ovf_in       = ovf_ff | vel_sat.ovf;
                     ax_in        = !ax_ff;
                     if (ax_ff) begin
                        state_in = ST_DONE;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               out_index_in  = step_count_ff;
               out_pos_in    = np_ff;
               out_vel_in    = nv_ff;
               out_acc_in    = na_ff;
               out_ovf_in    = ovf_ff;
               out_sing_in   = sing_ff;
               p_in          = np_ff;
               v_in          = nv_ff;
               a_in          = na_ff;
               step_count_in = step_count_ff + 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_VDT;
         ax_ff         <= 1'b0;
         dt_ff         <= '0;
         m_ff          <= '0;
         attr_ff[0]    <= '0;
         attr_ff[1]    <= '0;
         p_ff[0]       <= '0;
         p_ff[1]       <= '0;
         v_ff[0]       <= '0;
         v_ff[1]       <= '0;
         a_ff[0]       <= '0;
         a_ff[1]       <= '0;
         step_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         ovf_ff        <= 1'b0;
         sing_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         ax_ff         <= ax_in;
         dt_ff         <= dt_in;
         m_ff          <= m_in;
         attr_ff       <= attr_in;
         p_ff          <= p_in;
         v_ff          <= v_in;
         a_ff          <= a_in;
         step_count_ff <= step_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         ovf_ff        <= ovf_in;
         sing_ff       <= sing_in;
      end
   end

   always_ff @(posedge clock) begin
      np_ff        <= np_in;
      nv_ff        <= nv_in;
      na_ff        <= na_in;
      r_ff         <= r_in;
      acc_ff       <= acc_in;
      tmp_ff       <= tmp_in;
      d_ff         <= d_in;
      out_index_ff <= out_index_in;
      out_pos_ff   <= out_pos_in;
      out_vel_ff   <= out_vel_in;
      out_acc_ff   <= out_acc_in;
      out_ovf_ff   <= out_ovf_in;
      out_sing_ff  <= out_sing_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_index    = out_index_ff;
   assign rsp_pos_x_out     = out_pos_ff[0];
   assign rsp_pos_y_out     = out_pos_ff[1];
   assign rsp_vel_x_out     = out_vel_ff[0];
   assign rsp_vel_y_out     = out_vel_ff[1];
   assign rsp_acc_x_out     = out_acc_ff[0];
   assign rsp_acc_y_out     = out_acc_ff[1];
   assign rsp_overflow_flag = out_ovf_ff;
   assign rsp_singular_flag = out_sing_ff;

   a_singular_no_force: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular_flag) |-> (rsp_acc_x_out == '0 && rsp_acc_y_out == '0))
      else $error("singular result carries nonzero acceleration");

   a_index_matches: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid && rsp_step_index == $past(step_count_ff)
                    && step_count_ff == $past(step_count_ff) + 1'b1))
      else $error("step index and counter out of line");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_step_index)
                                    && $stable(rsp_pos_x_out) && $stable(rsp_vel_y_out)))
      else $error("stalled result item changed");

endmodule
